>>> design/ps2mct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ps2mct_pkg;

	localparam int SIZE_W   = 13;
	localparam int CURSOR_W = 12;
	localparam int BYTE_W   = 8;
	localparam int MOVE_W   = 9;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

	localparam logic [SIZE_W-1:0] SCREEN_WIDTH_RESET  = 13'd1024;
	localparam logic [SIZE_W-1:0] SCREEN_HEIGHT_RESET = 13'd768;

	localparam int RESET_X = 400;
	localparam int RESET_Y = 300;

	localparam int HDR_LEFT_BIT   = 0;
	localparam int HDR_SYNC_BIT   = 3;
	localparam int HDR_X_SIGN_BIT = 4;
	localparam int HDR_Y_SIGN_BIT = 5;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_XMOVE  = 2'd1,
		PH_YMOVE  = 2'd2
	} phase_t;

endpackage

`default_nettype wire

>>> design/ps2_mouse_packet_cursor_tracker.sv
// A byte accepted into the input register is decoded from there; when the third byte
// of a packet advances, its result is loaded into the output register, which drives
// m_tvalid.
// Throughput: one byte per cycle; the input register stalls only while a result
// waits in the output register.
// Reset (arst_n low, asynchronous): phase waits for a header, cursor 400,300 (saturated
// to the coordinate range), buttons 0, screen 1024 x 768, no beat pending.
`timescale 1ns / 1ps
`default_nettype none

module ps2_mouse_packet_cursor_tracker #(
	parameter int COORD_WIDTH = 12
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [ps2mct_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ps2mct_pkg::SIZE_W-1:0]         cfg_data,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	// rx_byte[7:0]
	input  wire logic [7:0]                            s_tdata,
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// cursor_x[11:0], cursor_y[23:12], left_button[24], prev_left_button[25], zero[31:26]
	output logic [31:0]                                m_tdata
);

	localparam int CurW = ps2mct_pkg::CURSOR_W;
	localparam int SW   = ps2mct_pkg::SIZE_W;
	localparam int MW   = ps2mct_pkg::MOVE_W;
	localparam int BW   = ps2mct_pkg::BYTE_W;
	localparam int CoordMax = (1 << COORD_WIDTH) - 1;
	localparam int ResetXInt = (ps2mct_pkg::RESET_X > CoordMax) ? CoordMax
		: ps2mct_pkg::RESET_X;
	localparam int ResetYInt = (ps2mct_pkg::RESET_Y > CoordMax) ? CoordMax
		: ps2mct_pkg::RESET_Y;
	localparam logic [COORD_WIDTH-1:0] ResetX = COORD_WIDTH'(ResetXInt);
	localparam logic [COORD_WIDTH-1:0] ResetY = COORD_WIDTH'(ResetYInt);

	logic [SW-1:0]          screen_width_q;
	logic [SW-1:0]          screen_height_q;

	logic                   valid_s1;
	logic [BW-1:0]          byte_s1;

	ps2mct_pkg::phase_t     phase_q;
	ps2mct_pkg::phase_t     phase_d;
	logic [BW-1:0]          header_q;
	logic [BW-1:0]          xmove_q;
	logic [COORD_WIDTH-1:0] pos_x_q;
	logic [COORD_WIDTH-1:0] pos_y_q;
	logic                   left_now_q;
	logic                   left_before_q;

	logic                   out_valid_q;
	logic [31:0]            out_data_q;

	logic                   advance;
	logic                   produce;
	logic                   take_header;
	logic                   take_xmove;
	logic [COORD_WIDTH-1:0] pos_x_new;
	logic [COORD_WIDTH-1:0] pos_y_new;
	logic [MW-1:0]          move_x;
	logic [MW-1:0]          move_y;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= ps2mct_pkg::SCREEN_WIDTH_RESET;
			screen_height_q <= ps2mct_pkg::SCREEN_HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == ps2mct_pkg::REG_SCREEN_WIDTH) begin
				screen_width_q <= cfg_data;
			end else if (cfg_index == ps2mct_pkg::REG_SCREEN_HEIGHT) begin
				screen_height_q <= cfg_data;
			end
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			ps2mct_pkg::PH_HEADER: begin
				if (byte_s1[ps2mct_pkg::HDR_SYNC_BIT]) begin
					phase_d = ps2mct_pkg::PH_XMOVE;
				end
			end
			ps2mct_pkg::PH_XMOVE: begin
				phase_d = ps2mct_pkg::PH_YMOVE;
			end
			default: begin
				phase_d = ps2mct_pkg::PH_HEADER;
			end
		endcase
	end

	// per-phase actions
	always_comb begin
		take_header = 1'b0;
		take_xmove  = 1'b0;
		produce     = 1'b0;
		unique case (phase_q)
			ps2mct_pkg::PH_HEADER: begin
				take_header = byte_s1[ps2mct_pkg::HDR_SYNC_BIT];
			end
			ps2mct_pkg::PH_XMOVE: begin
				take_xmove = 1'b1;
			end
			default: begin
				produce = 1'b1;
			end
		endcase
	end

	assign move_x = {header_q[ps2mct_pkg::HDR_X_SIGN_BIT], xmove_q};
	assign move_y = {header_q[ps2mct_pkg::HDR_Y_SIGN_BIT], byte_s1};

	ps2mct_clamp #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_clamp_x (
		.pos      (pos_x_q),
		.move     (move_x),
		.subtract (1'b0),
		.size     (screen_width_q),
		.pos_next (pos_x_new)
	);

	ps2mct_clamp #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_clamp_y (
		.pos      (pos_y_q),
		.move     (move_y),
		.subtract (1'b1),
		.size     (screen_height_q),
		.pos_next (pos_y_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= ps2mct_pkg::PH_HEADER;
			header_q      <= '0;
			xmove_q       <= '0;
			pos_x_q       <= ResetX;
			pos_y_q       <= ResetY;
			left_now_q    <= 1'b0;
			left_before_q <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			if (take_header) begin
				header_q <= byte_s1;
			end
			if (take_xmove) begin
				xmove_q <= byte_s1;
			end
			if (produce) begin
				pos_x_q       <= pos_x_new;
				pos_y_q       <= pos_y_new;
				left_now_q    <= header_q[ps2mct_pkg::HDR_LEFT_BIT];
				left_before_q <= left_now_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && produce) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			out_data_q <= {6'b0, left_now_q, header_q[ps2mct_pkg::HDR_LEFT_BIT],
				CurW'(pos_y_new), CurW'(pos_x_new)};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance && produce |=> m_tvalid)
		else $error("completed packet did not reach the output register");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled with an empty input register");

	a_drop_unsynced: assert property (@(posedge clk) disable iff (!arst_n)
		advance && phase_q == ps2mct_pkg::PH_HEADER && !byte_s1[ps2mct_pkg::HDR_SYNC_BIT]
		|=> phase_q == ps2mct_pkg::PH_HEADER)
		else $error("header without sync bit left the header phase");

	a_prev_button: assert property (@(posedge clk) disable iff (!arst_n)
		advance && produce |=> left_before_q == $past(left_now_q))
		else $error("previous left button not carried over");

endmodule

`default_nettype wire

>>> design/ps2mct_clamp.sv
`timescale 1ns / 1ps
`default_nettype none

module ps2mct_clamp #(
	parameter int COORD_WIDTH = 12
) (
	input  wire logic [COORD_WIDTH-1:0]              pos,
	input  wire logic [ps2mct_pkg::MOVE_W-1:0]       move,
	input  wire logic                                subtract,
	input  wire logic [ps2mct_pkg::SIZE_W-1:0]       size,
	output logic      [COORD_WIDTH-1:0]              pos_next
);

	localparam int SW = ps2mct_pkg::SIZE_W;
	localparam int MW = ps2mct_pkg::MOVE_W;
	localparam int LW = (COORD_WIDTH + 1 > SW) ? COORD_WIDTH + 1 : SW;
	localparam int VW = COORD_WIDTH + 2;

	logic        [LW-1:0] size_ext;
	logic        [LW-1:0] lim_max;
	logic        [LW-1:0] lim;
	logic signed [VW-1:0] pos_ext;
	logic signed [VW-1:0] move_ext;
	logic signed [VW-1:0] sum;
	logic        [LW-1:0] sum_mag;

	always_comb begin
		size_ext = LW'(size);
		lim_max  = LW'(1) << COORD_WIDTH;
		if (size_ext > lim_max) begin
			lim = lim_max;
		end else if (size_ext == '0) begin
			lim = LW'(1);
		end else begin
			lim = size_ext;
		end
	end

	always_comb begin
		pos_ext  = $signed({2'b00, pos});
		move_ext = $signed({{(VW-MW){move[MW-1]}}, move});
		if (subtract) begin
			sum = pos_ext - move_ext;
		end else begin
			sum = pos_ext + move_ext;
		end
		sum_mag = LW'(sum[VW-2:0]);
		if (sum[VW-1]) begin
			pos_next = '0;
		end else if (sum_mag >= lim) begin
			pos_next = COORD_WIDTH'(lim - LW'(1));
		end else begin
			pos_next = sum[COORD_WIDTH-1:0];
		end
	end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int COORD_LIM    = 1 << ps2mct_pkg::CURSOR_W;
	localparam int IDLE_PCT     = 12;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_ITEMS  = 200;
	localparam logic [ps2mct_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [ps2mct_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef struct packed {
		logic                            prev_left;
		logic                            left;
		logic [ps2mct_pkg::CURSOR_W-1:0] y;
		logic [ps2mct_pkg::CURSOR_W-1:0] x;
	} cursor_rpt_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [ps2mct_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [ps2mct_pkg::SIZE_W-1:0]    cfg_data = '0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [7:0]                       s_tdata = '0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [31:0]                      m_tdata;

	logic [7:0]  rx_byte_q[$];
	cursor_rpt_t cursor_rpt_q[$];
	logic        calm = 1'b0;
	int          errors = 0;
	int          quiet_cycles = 0;

	ps2mct_pkg::phase_t            pkt_phase = ps2mct_pkg::PH_HEADER;
	logic [7:0]                    hdr_byte = '0;
	logic [7:0]                    x_byte = '0;
	int                            pos_x = (ps2mct_pkg::RESET_X >= COORD_LIM) ? COORD_LIM - 1
		: ps2mct_pkg::RESET_X;
	int                            pos_y = (ps2mct_pkg::RESET_Y >= COORD_LIM) ? COORD_LIM - 1
		: ps2mct_pkg::RESET_Y;
	logic                          cur_left = 1'b0;
	logic                          prev_left = 1'b0;
	logic [ps2mct_pkg::SIZE_W-1:0] width_reg = ps2mct_pkg::SCREEN_WIDTH_RESET;
	logic [ps2mct_pkg::SIZE_W-1:0] height_reg = ps2mct_pkg::SCREEN_HEIGHT_RESET;

	ps2_mouse_packet_cursor_tracker u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #10 clk = ~clk;

	function automatic int clamp_coord(int v, logic [ps2mct_pkg::SIZE_W-1:0] size);
		int lim;
		lim = int'(size);
		if (lim < 1)
			lim = 1;
		if (lim > COORD_LIM)
			lim = COORD_LIM;
		if (v < 0)
			v = 0;
		if (v >= lim)
			v = lim - 1;
		return v;
	endfunction

	task automatic track_byte(input logic [7:0] b);
		int          dx;
		int          dy;
		cursor_rpt_t rpt;
		case (pkt_phase)
		ps2mct_pkg::PH_HEADER: begin
			if (b[ps2mct_pkg::HDR_SYNC_BIT]) begin
				hdr_byte = b;
				pkt_phase = ps2mct_pkg::PH_XMOVE;
			end
		end
		ps2mct_pkg::PH_XMOVE: begin
			x_byte = b;
			pkt_phase = ps2mct_pkg::PH_YMOVE;
		end
		default: begin
			pkt_phase = ps2mct_pkg::PH_HEADER;
			prev_left = cur_left;
			cur_left = hdr_byte[ps2mct_pkg::HDR_LEFT_BIT];
			dx = hdr_byte[ps2mct_pkg::HDR_X_SIGN_BIT] ? int'(x_byte) - 256 : int'(x_byte);
			dy = hdr_byte[ps2mct_pkg::HDR_Y_SIGN_BIT] ? int'(b) - 256 : int'(b);
			pos_x = clamp_coord(pos_x + dx, width_reg);
			pos_y = clamp_coord(pos_y - dy, height_reg);
			rpt.x = pos_x[ps2mct_pkg::CURSOR_W-1:0];
			rpt.y = pos_y[ps2mct_pkg::CURSOR_W-1:0];
			rpt.left = cur_left;
			rpt.prev_left = prev_left;
			cursor_rpt_q.push_back(rpt);
		end
		endcase
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (rx_byte_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
				s_tdata <= rx_byte_q.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	always @(posedge clk) begin : mon
		cursor_rpt_t got;
		cursor_rpt_t want;
		logic        beat;
		if (arst_n) begin
			beat = 1'b0;
			if (m_tvalid && m_tready) begin
				beat = 1'b1;
				got = m_tdata[25:0];
				if (cursor_rpt_q.size() == 0) begin
					errors++;
					$display("%0t: expected none, actual x=%0d y=%0d left=%0b prev=%0b",
						$time, got.x, got.y, got.left, got.prev_left);
				end else begin
					want = cursor_rpt_q.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t: expected %0d,%0d,%0b,%0b actual %0d,%0d,%0b,%0b",
							$time, want.x, want.y, want.left, want.prev_left,
							got.x, got.y, got.left, got.prev_left);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				beat = 1'b1;
				track_byte(s_tdata);
			end
			if (cfg_valid && cfg_ready) begin
				beat = 1'b1;
				if (cfg_index == ps2mct_pkg::REG_SCREEN_WIDTH)
					width_reg = cfg_data;
				else if (cfg_index == ps2mct_pkg::REG_SCREEN_HEIGHT)
					height_reg = cfg_data;
			end
			quiet_cycles = beat ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	task automatic drain();
		while (rx_byte_q.size() != 0 || s_tvalid || cursor_rpt_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ps2mct_pkg::CFG_IDX_W-1:0] idx,
			input logic [ps2mct_pkg::SIZE_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic set_screen(input logic [ps2mct_pkg::SIZE_W-1:0] w,
			input logic [ps2mct_pkg::SIZE_W-1:0] h, input bit spare);
		drain();
		write_reg(ps2mct_pkg::REG_SCREEN_WIDTH, w);
		write_reg(ps2mct_pkg::REG_SCREEN_HEIGHT, h);
		if (spare) begin
			write_reg(REG_SPARE_2, ps2mct_pkg::SIZE_W'($urandom));
			write_reg(REG_SPARE_3, ps2mct_pkg::SIZE_W'($urandom));
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_packet(input logic [7:0] hdr, input logic [7:0] xm, input logic [7:0] ym);
		rx_byte_q.push_back(hdr);
		rx_byte_q.push_back(xm);
		rx_byte_q.push_back(ym);
	endtask

	task automatic queue_rand_packet(input int drift_x, input int drift_y);
		logic [7:0] hdr;
		logic [7:0] xm;
		logic [7:0] ym;
		hdr = 8'($urandom);
		hdr[ps2mct_pkg::HDR_SYNC_BIT] = 1'b1;
		xm = 8'($urandom);
		ym = 8'($urandom);
		// push the cursor toward an edge on about half the packets
		if (drift_x != 0 && $urandom_range(0, 1)) begin
			hdr[ps2mct_pkg::HDR_X_SIGN_BIT] = drift_x < 0;
			xm = (drift_x < 0) ? 8'($urandom_range(0, 127)) : 8'($urandom_range(128, 255));
		end
		if (drift_y != 0 && $urandom_range(0, 1)) begin
			hdr[ps2mct_pkg::HDR_Y_SIGN_BIT] = drift_y > 0;
			ym = (drift_y > 0) ? 8'($urandom_range(0, 127)) : 8'($urandom_range(128, 255));
		end
		queue_packet(hdr, xm, ym);
	endtask

	initial begin
		int         cnt;
		int         sel;
		int         drift_x;
		int         drift_y;
		logic [7:0] junk;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		rx_byte_q.push_back(8'h00);
		rx_byte_q.push_back(8'hF7);
		queue_packet(8'h08, 8'h00, 8'h00);
		queue_packet(8'h19, 8'h00, 8'hFF);
		queue_packet(8'hF9, 8'hFF, 8'h00);
		queue_packet(8'h28, 8'h7F, 8'h80);
		queue_packet(8'h0E, 8'h55, 8'hAA);
		rx_byte_q.push_back(8'h08);
		rx_byte_q.push_back(8'h12);
		queue_packet(8'h3B, 8'h01, 8'hFE);

		for (int p = 0; p < 8; p++) begin
			case (p)
			0: set_screen(ps2mct_pkg::SCREEN_WIDTH_RESET, ps2mct_pkg::SCREEN_HEIGHT_RESET, 1'b0);
			1: set_screen('0, '0, 1'b0);
			2: set_screen('1, '1, 1'b1);
			3: set_screen(ps2mct_pkg::SIZE_W'(COORD_LIM), ps2mct_pkg::SIZE_W'(COORD_LIM), 1'b0);
			4: set_screen(ps2mct_pkg::SIZE_W'(1), ps2mct_pkg::SIZE_W'(COORD_LIM - 1), 1'b0);
			5: set_screen(ps2mct_pkg::SIZE_W'(COORD_LIM - 1), ps2mct_pkg::SIZE_W'(1), 1'b0);
			6: set_screen(ps2mct_pkg::SIZE_W'($urandom_range(1, COORD_LIM)),
				ps2mct_pkg::SIZE_W'($urandom_range(1, COORD_LIM)), 1'b0);
			default: set_screen(ps2mct_pkg::SIZE_W'($urandom),
				ps2mct_pkg::SIZE_W'($urandom), 1'b1);
			endcase
			calm = (p == 3);
			drift_x = int'($urandom_range(0, 2)) - 1;
			drift_y = int'($urandom_range(0, 2)) - 1;
			cnt = 0;
			while (cnt < PHASE_ITEMS) begin
				sel = int'($urandom_range(0, 99));
				if (sel < 80) begin
					queue_rand_packet(drift_x, drift_y);
					cnt += 3;
				end else if (sel < 90) begin
					rx_byte_q.push_back(8'($urandom));
					cnt++;
				end else if (sel < 95) begin
					// broken packet: header and one move byte only
					junk = 8'($urandom);
					junk[ps2mct_pkg::HDR_SYNC_BIT] = 1'b1;
					rx_byte_q.push_back(junk);
					rx_byte_q.push_back(8'($urandom));
					cnt += 2;
				end else begin
					junk = 8'($urandom);
					junk[ps2mct_pkg::HDR_SYNC_BIT] = 1'b0;
					rx_byte_q.push_back(junk);
					cnt++;
				end
			end
		end

		drain();
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> ps2_mouse_packet_cursor_tracker.f
design/ps2mct_pkg.sv
design/ps2mct_clamp.sv
design/ps2_mouse_packet_cursor_tracker.sv
tb/tb_top.sv
